[design/kct_pkg.sv]
// ----------------------------------------------------------------------------
// kct_pkg
// shared types, codes and field widths of the keyed count table
// ----------------------------------------------------------------------------
package kct_pkg;

  // default table geometry
  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int DEF_ID_BITS       = 16;
  localparam int DEF_COUNT_BITS    = 16;

  // fixed port field widths
  localparam int ITEM_W   = 16;
  localparam int AMOUNT_W = 16;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 16;
  localparam int USED_W   = 6;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SWAP   = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    req_t                req_type;
    logic [ITEM_W-1:0]   item_id;
    logic [AMOUNT_W-1:0] amount;
    logic [POS_W-1:0]    first_position;
    logic [POS_W-1:0]    second_position;
  } kct_in_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   entry_position;
    logic [COUNT_W-1:0] entry_count;
    logic               entry_erased;
    logic               count_saturated;
    logic [USED_W-1:0]  entries_used;
  } kct_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_W,
    S_SWAP_X,
    S_DONE
  } state_t;

  // memory read source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_PA,
    RD_PB
  } rd_sel_t;

  // memory write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ADD_HIT,
    WR_APPEND,
    WR_SUB,
    WR_SHIFT,
    WR_SWAP_A,
    WR_SWAP_B
  } wr_sel_t;

  // result capture source
  typedef enum logic [2:0] {
    RES_NONE,
    RES_WRITE,
    RES_FOUND,
    RES_ERASED,
    RES_MISSING,
    RES_FULL,
    RES_RANGE
  } res_sel_t;

  typedef struct packed {
    logic     load;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    res_sel_t res_sel;
    logic     erase_start;
    logic     used_dec;
    logic     push;
  } kct_cmd_t;

  typedef struct packed {
    req_t req;
    logic hit;
    logic more;
    logic full;
    logic drop;
    logic in_range;
    logic rd_vld;
    logic out_free;
  } kct_sts_t;

endpackage

[design/keyed_count_table.sv]
// add, remove and lookup scan the table from position 0 until the item is found or the
//   used entries run out; an erase then shifts each later entry down by one position,
//   with no shift when the last entry goes; a result that cannot leave holds the block
// swap reads both positions and writes them back crossed; one request is worked on at a time
// rate is set by the single read port of the entry memory: one entry per cycle
// reset: entry count cleared at once, entry memory left as is (no clearing pass)
// ----------------------------------------------------------------------------
// keyed_count_table
// ordered, compacted table of item ids with saturating counts
// ----------------------------------------------------------------------------
module keyed_count_table import kct_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ID_BITS       = DEF_ID_BITS,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kct_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output kct_out_t out_data
);

  // command and status between sequencer and datapath
  kct_cmd_t cmd;
  kct_sts_t sts;

  // sequencer: accepts a request only when idle, walks the table through the
  // memory read port and parks in a done state until the result register frees
  kct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: entry memories, scan pointer, count arithmetic and the result
  // register, which holds a finished result while the next request comes in
  kct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_BITS       (ID_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one request in flight: no back-to-back accept
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a result is only pushed into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("result pushed over an unsent result");

  // failed requests carry no position, count or flags
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.entry_count == '0 && out_data.entry_position == '0 &&
      !out_data.entry_erased && !out_data.count_saturated)
    else $error("failed request with payload");

  // an erased entry reports count zero and never saturation
  a_erase_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.entry_erased |->
      out_data.entry_count == '0 && !out_data.count_saturated)
    else $error("erased entry with non-zero count");

endmodule

[design/kct_datapath.sv]
// ----------------------------------------------------------------------------
// kct_datapath
// entry memories, scan pointer, count arithmetic and result registers
// ----------------------------------------------------------------------------
module kct_datapath import kct_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ID_BITS       = DEF_ID_BITS,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  kct_in_t  in_data,
  input  kct_cmd_t cmd,
  output kct_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output kct_out_t out_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = (ID_BITS < ITEM_W) ? ID_BITS : ITEM_W;
  localparam int SW = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
  localparam int PW = (UW > POS_W) ? UW : POS_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [ID_BITS-1:0]    id_mem  [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];

  kct_in_t               req_r;
  logic [UW-1:0]         used_r;
  logic [UW-1:0]         ptr_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_pos_r;
  logic [ID_BITS-1:0]    id_rd_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [ID_BITS-1:0]    hold_id_r;
  logic [COUNT_BITS-1:0] hold_cnt_r;
  kct_out_t              res_r;
  logic                  out_valid_r;
  kct_out_t              out_data_r;

  logic [ID_BITS-1:0]    key;
  logic [AW-1:0]         addr_pa;
  logic [AW-1:0]         addr_pb;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] add_base;
  logic [SW-1:0]         sum;
  logic                  sum_sat;
  logic [COUNT_BITS-1:0] add_cnt;
  logic [COUNT_BITS-1:0] sub_cnt;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ID_BITS-1:0]    wr_id;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  wr_sat;
  kct_out_t              push_data;

  assign key     = ID_BITS'(req_r.item_id[KW-1:0]);
  assign addr_pa = AW'(req_r.first_position);
  assign addr_pb = AW'(req_r.second_position);

  // read port
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = ptr_r[AW-1:0];
    case (cmd.rd_sel)
      RD_PTR:  rd_addr = ptr_r[AW-1:0];
      RD_PA:   rd_addr = addr_pa;
      RD_PB:   rd_addr = addr_pb;
      default: rd_en   = 1'b0;
    endcase
  end

  // count arithmetic
  assign add_base = (cmd.wr_sel == WR_APPEND) ? '0 : cnt_rd_r;
  assign sum      = SW'(add_base) + SW'(req_r.amount);
  assign sum_sat  = sum > SW'(COUNT_MAX);
  assign add_cnt  = sum_sat ? COUNT_MAX : sum[COUNT_BITS-1:0];
  assign sub_cnt  = cnt_rd_r - COUNT_BITS'(req_r.amount);

  // write port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = rd_pos_r;
    wr_id   = key;
    wr_cnt  = cnt_rd_r;
    wr_sat  = 1'b0;
    case (cmd.wr_sel)
      WR_ADD_HIT: begin
        wr_cnt = add_cnt;
        wr_sat = sum_sat;
      end
      WR_APPEND: begin
        wr_addr = used_r[AW-1:0];
        wr_cnt  = add_cnt;
        wr_sat  = sum_sat;
      end
      WR_SUB: begin
        wr_cnt = sub_cnt;
      end
      WR_SHIFT: begin
        wr_addr = rd_pos_r - AW'(1);
        wr_id   = id_rd_r;
      end
      WR_SWAP_A: begin
        wr_addr = addr_pa;
        wr_id   = id_rd_r;
      end
      WR_SWAP_B: begin
        wr_addr = addr_pb;
        wr_id   = hold_id_r;
        wr_cnt  = hold_cnt_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    sts.req      = req_r.req_type;
    sts.hit      = rd_vld_r && (id_rd_r == key);
    sts.more     = ptr_r < used_r;
    sts.full     = used_r == UW'(TABLE_ENTRIES);
    sts.drop     = SW'(req_r.amount) >= SW'(cnt_rd_r);
    sts.in_range = (PW'(req_r.first_position) < PW'(used_r)) &&
                   (PW'(req_r.second_position) < PW'(used_r));
    sts.rd_vld   = rd_vld_r;
    sts.out_free = !out_valid_r || out_ready;
  end

  // finished result with the current entry count
  always_comb begin
    push_data              = res_r;
    push_data.entries_used = USED_W'(used_r);
  end

  // memories and payload registers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      id_rd_r  <= id_mem[rd_addr];
      cnt_rd_r <= cnt_mem[rd_addr];
      rd_pos_r <= rd_addr;
    end
    if (cmd.rd_sel == RD_PB) begin
      hold_id_r  <= id_rd_r;
      hold_cnt_r <= cnt_rd_r;
    end
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.load) begin
      res_r <= '0;
    end else begin
      case (cmd.res_sel)
        RES_WRITE: begin
          res_r.entry_position  <= POS_W'(wr_addr);
          res_r.entry_count     <= COUNT_W'(wr_cnt);
          res_r.count_saturated <= wr_sat;
        end
        RES_FOUND: begin
          res_r.entry_position <= POS_W'(rd_pos_r);
          res_r.entry_count    <= COUNT_W'(cnt_rd_r);
        end
        RES_ERASED: begin
          res_r.entry_position <= POS_W'(rd_pos_r);
          res_r.entry_erased   <= 1'b1;
        end
        RES_MISSING: res_r.status <= ST_MISSING;
        RES_FULL:    res_r.status <= ST_FULL;
        RES_RANGE:   res_r.status <= ST_RANGE;
        default: ;
      endcase
    end
    if (cmd.push) begin
      out_data_r <= push_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (cmd.wr_sel == WR_APPEND) begin
        used_r <= used_r + UW'(1);
      end else if (cmd.used_dec) begin
        used_r <= used_r - UW'(1);
      end
      if (cmd.load) begin
        ptr_r <= '0;
      end else if (cmd.erase_start) begin
        ptr_r <= UW'(rd_pos_r) + UW'(1);
      end else if (cmd.rd_sel == RD_PTR) begin
        ptr_r <= ptr_r + UW'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/kct_ctrl.sv]
// ----------------------------------------------------------------------------
// kct_ctrl
// request sequencer: scan, update, shift on erase, swap and result hand-off
// ----------------------------------------------------------------------------
module kct_ctrl import kct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kct_sts_t sts,
  output kct_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.req == REQ_SWAP) begin
          state_nxt = S_SWAP_A;
        end else if (sts.hit) begin
          state_nxt = S_DONE;
          case (sts.req)
            REQ_ADD: begin
              cmd.wr_sel  = WR_ADD_HIT;
              cmd.res_sel = RES_WRITE;
            end
            REQ_REMOVE: begin
              if (sts.drop) begin
                cmd.res_sel     = RES_ERASED;
                cmd.erase_start = 1'b1;
                state_nxt       = S_SHIFT;
              end else begin
                cmd.wr_sel  = WR_SUB;
                cmd.res_sel = RES_WRITE;
              end
            end
            default: cmd.res_sel = RES_FOUND;
          endcase
        end else if (sts.more) begin
          cmd.rd_sel = RD_PTR;
        end else begin
          state_nxt = S_DONE;
          if (sts.req == REQ_ADD) begin
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.wr_sel  = WR_APPEND;
              cmd.res_sel = RES_WRITE;
            end
          end else begin
            cmd.res_sel = RES_MISSING;
          end
        end
      end
      S_SHIFT: begin
        if (sts.rd_vld) begin
          cmd.wr_sel = WR_SHIFT;
        end
        if (sts.more) begin
          cmd.rd_sel = RD_PTR;
        end else if (!sts.rd_vld) begin
          cmd.used_dec = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_SWAP_A: begin
        if (sts.in_range) begin
          cmd.rd_sel = RD_PA;
          state_nxt  = S_SWAP_B;
        end else begin
          cmd.res_sel = RES_RANGE;
          state_nxt   = S_DONE;
        end
      end
      S_SWAP_B: begin
        cmd.rd_sel = RD_PB;
        state_nxt  = S_SWAP_W;
      end
      S_SWAP_W: begin
        cmd.wr_sel  = WR_SWAP_A;
        cmd.res_sel = RES_WRITE;
        state_nxt   = S_SWAP_X;
      end
      S_SWAP_X: begin
        cmd.wr_sel = WR_SWAP_B;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
